// ----- sv/isa_pkg.sv -----
// Shared types and codes for the interval set block.
// No dependencies; the interval set module refers to this package by scoped names.
package isa_pkg;

    // Command codes carried on the input channel.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Status codes returned with every result beat.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_EMIT2,
        S_FINAL,
        S_READ,
        S_DONE
    } t_state;

endpackage

// ----- sv/isa_if.sv -----
// Valid/ready channel interfaces for the interval set block.
// Depends on nothing; field widths are fixed by the block's item format.
interface isa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] pos;
    logic [31:0] length;
    logic [5:0]  index;

    modport source (output valid, cmd, pos, length, index, input ready);
    modport sink (input valid, cmd, pos, length, index, output ready);
endinterface

interface isa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [31:0] entry_start;
    logic [31:0] entry_length;

    modport source (output valid, status, entry_count, entry_start, entry_length, input ready);
    modport sink (input valid, status, entry_count, entry_start, entry_length, output ready);
endinterface

// ----- sv/isa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module isa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/interval_set_add_remove.sv -----
// Interval set: sorted table of disjoint closed intervals with add, remove and read.
// Depends on isa_pkg, isa_if (isa_in_if, isa_out_if) and isa_ram.
//
//   channel | dir | beat contents
//   i_in    | in  | cmd, pos, length, index
//   o_out   | out | status, entry_count, entry_start, entry_length
//
// A read passes through the read state and the result state before its result
// reaches the result register. An ignored, out-of-range or unused-command beat
// goes straight to the result state. An add or remove walks the whole table
// through one RAM read port: a fetch and an evaluate state per entry, a second
// write state for an entry that is split or for the first entry after the
// inserted range, then a final write state and the result state.
// The new table is written into the other of two RAM banks and the banks swap
// only when the item succeeds, so a full table is left untouched.
// Reset clears the sequencer, the count, the bank select and the result valid;
// the RAMs need no clearing pass.
// A stalled result holds in the output register; the next beat is accepted
// meanwhile and its result waits in the result state until the register drains.
module interval_set_add_remove #(
    parameter int CAPACITY = 64,
    parameter int POS_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isa_in_if.sink    i_in,
    isa_out_if.source o_out
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = POS_BITS;
    localparam int EW   = PW + 1;
    localparam int SW   = ((PW > 32) ? PW : 32) + 1;
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int DW   = 2 * PW;

    isa_pkg::t_state r_state, n_state;

    logic          r_sel;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_n;
    logic          r_over;
    logic          r_placed;
    logic [1:0]    r_cmd;
    logic [PW-1:0] r_s, r_e, r_ms, r_me, r_ps, r_pe;
    logic [1:0]    r_status;
    logic [31:0]   r_rs, r_rl;
    logic          r_o_valid;
    logic [1:0]    r_o_status;
    logic [6:0]    r_o_count;
    logic [31:0]   r_o_start, r_o_len;

    // Input decode: wrapped start, saturated end, index check.
    logic [PW-1:0] in_s, in_e;
    logic [SW-1:0] in_sum;
    logic          in_zero, idx_ok, accept;

    always_comb begin
        in_s    = PW'(i_in.pos);
        in_sum  = SW'(in_s) + SW'(i_in.length) - SW'(1);
        in_e    = (in_sum > SW'({PW{1'b1}})) ? {PW{1'b1}} : in_sum[PW-1:0];
        in_zero = (i_in.length == 32'd0);
        idx_ok  = (CMPW'(i_in.index) < CMPW'(r_count));
        accept  = i_in.valid && i_in.ready;
    end

    // RAM banks: read the current bank, write the new table into the other.
    logic [AW-1:0] raddr;
    logic [DW-1:0] rd0, rd1, rdata;
    logic          emit_en, we, full;
    logic [PW-1:0] emit_s, emit_e;

    isa_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_bank0 (
        .i_clk  (i_clk),
        .i_we   (we && r_sel),
        .i_waddr(r_n[AW-1:0]),
        .i_wdata({emit_e, emit_s}),
        .i_raddr(raddr),
        .o_rdata(rd0)
    );

    isa_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_bank1 (
        .i_clk  (i_clk),
        .i_we   (we && !r_sel),
        .i_waddr(r_n[AW-1:0]),
        .i_wdata({emit_e, emit_s}),
        .i_raddr(raddr),
        .o_rdata(rd1)
    );

    // Current entry and its relation to the item's range.
    logic [PW-1:0] ent_a, ent_b;
    logic          add_below, add_above, rem_disj, rem_left, rem_right, is_add;

    always_comb begin
        rdata     = r_sel ? rd1 : rd0;
        ent_a     = rdata[PW-1:0];
        ent_b     = rdata[DW-1:PW];
        is_add    = (r_cmd == isa_pkg::CMD_ADD);
        add_below = (EW'(ent_b) + EW'(1)) < EW'(r_s);
        add_above = EW'(ent_a) > (EW'(r_e) + EW'(1));
        rem_disj  = (ent_b < r_s) || (ent_a > r_e);
        rem_left  = ent_a < r_s;
        rem_right = ent_b > r_e;
    end

    // Next state.
    logic last;
    logic need2;

    always_comb begin
        last    = (CW'(r_i + 1'b1) == r_count);
        n_state = r_state;
        unique case (r_state)
            isa_pkg::S_IDLE: begin
                if (accept) begin
                    priority if (i_in.cmd == isa_pkg::CMD_ADD
                                 || i_in.cmd == isa_pkg::CMD_REMOVE) begin
                        if (in_zero) begin
                            n_state = isa_pkg::S_DONE;
                        end else if (r_count == '0) begin
                            n_state = isa_pkg::S_FINAL;
                        end else begin
                            n_state = isa_pkg::S_FETCH;
                        end
                    end else if (i_in.cmd == isa_pkg::CMD_READ && idx_ok) begin
                        n_state = isa_pkg::S_READ;
                    end else begin
                        n_state = isa_pkg::S_DONE;
                    end
                end
            end
            isa_pkg::S_FETCH: n_state = isa_pkg::S_EVAL;
            isa_pkg::S_EVAL: begin
                if (need2) begin
                    n_state = isa_pkg::S_EMIT2;
                end else begin
                    n_state = last ? isa_pkg::S_FINAL : isa_pkg::S_FETCH;
                end
            end
            isa_pkg::S_EMIT2: n_state = last ? isa_pkg::S_FINAL : isa_pkg::S_FETCH;
            isa_pkg::S_FINAL: n_state = isa_pkg::S_DONE;
            isa_pkg::S_READ:  n_state = isa_pkg::S_DONE;
            isa_pkg::S_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_state = isa_pkg::S_IDLE;
                end
            end
            default: n_state = isa_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: read address, table writes, second-write plan.
    logic          adv;
    logic [PW-1:0] p_s, p_e;

    always_comb begin
        raddr   = r_i[AW-1:0];
        emit_en = 1'b0;
        emit_s  = ent_a;
        emit_e  = ent_b;
        need2   = 1'b0;
        p_s     = ent_a;
        p_e     = ent_b;
        adv     = 1'b0;
        unique case (r_state)
            isa_pkg::S_IDLE: raddr = AW'(i_in.index);
            isa_pkg::S_EVAL: begin
                if (is_add) begin
                    if (add_below) begin
                        emit_en = 1'b1;
                    end else if (add_above) begin
                        emit_en = 1'b1;
                        if (!r_placed) begin
                            emit_s = r_ms;
                            emit_e = r_me;
                            need2  = 1'b1;
                        end
                    end
                end else if (rem_disj) begin
                    emit_en = 1'b1;
                end else if (rem_left) begin
                    emit_en = 1'b1;
                    emit_e  = r_s - PW'(1);
                    need2   = rem_right;
                    p_s     = r_e + PW'(1);
                end else if (rem_right) begin
                    emit_en = 1'b1;
                    emit_s  = r_e + PW'(1);
                end
                adv = !need2;
            end
            isa_pkg::S_EMIT2: begin
                emit_en = 1'b1;
                emit_s  = r_ps;
                emit_e  = r_pe;
                adv     = 1'b1;
            end
            isa_pkg::S_FINAL: begin
                emit_en = is_add && !r_placed;
                emit_s  = r_ms;
                emit_e  = r_me;
            end
            default: ;
        endcase
        full = (r_n >= CW'(CAPACITY));
        we   = emit_en && !full;
    end

    assign i_in.ready = (r_state == isa_pkg::S_IDLE);

    // Result of a read of an entry, with its length saturated to 32 bits.
    logic [63:0] rd_len;

    always_comb begin
        rd_len = 64'(ent_b) - 64'(ent_a) + 64'd1;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= isa_pkg::S_IDLE;
            r_sel     <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == isa_pkg::S_FINAL && !(r_over || (emit_en && full))) begin
                r_sel   <= !r_sel;
                r_count <= r_n + CW'(we);
            end
            if (r_state == isa_pkg::S_DONE && (!r_o_valid || o_out.ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers of the table walk and the result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_in.cmd;
            r_s      <= in_s;
            r_e      <= in_e;
            r_ms     <= in_s;
            r_me     <= in_e;
            r_i      <= '0;
            r_n      <= '0;
            r_over   <= 1'b0;
            r_placed <= 1'b0;
            r_rs     <= 32'd0;
            r_rl     <= 32'd0;
            priority if ((i_in.cmd == isa_pkg::CMD_ADD || i_in.cmd == isa_pkg::CMD_REMOVE)
                         && in_zero) begin
                r_status <= isa_pkg::ST_IGNORED;
            end else if (i_in.cmd == isa_pkg::CMD_READ && !idx_ok) begin
                r_status <= isa_pkg::ST_BAD_INDEX;
            end else begin
                r_status <= isa_pkg::ST_OK;
            end
        end
        if (emit_en) begin
            if (full) begin
                r_over <= 1'b1;
            end else begin
                r_n <= r_n + 1'b1;
            end
        end
        if (r_state == isa_pkg::S_EVAL) begin
            r_ps <= p_s;
            r_pe <= p_e;
            if (is_add && add_above) begin
                r_placed <= 1'b1;
            end
            if (is_add && !add_below && !add_above) begin
                if (ent_a < r_ms) begin
                    r_ms <= ent_a;
                end
                if (ent_b > r_me) begin
                    r_me <= ent_b;
                end
            end
        end
        if (adv) begin
            r_i <= r_i + 1'b1;
        end
        if (r_state == isa_pkg::S_FINAL && (r_over || (emit_en && full))) begin
            r_status <= isa_pkg::ST_FULL;
        end
        if (r_state == isa_pkg::S_READ) begin
            r_rs <= 32'(ent_a);
            r_rl <= (rd_len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd_len[31:0];
        end
        if (r_state == isa_pkg::S_DONE && (!r_o_valid || o_out.ready)) begin
            r_o_status <= r_status;
            r_o_count  <= 7'(r_count);
            r_o_start  <= r_rs;
            r_o_len    <= r_rl;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_o_status;
    assign o_out.entry_count  = r_o_count;
    assign o_out.entry_start  = r_o_start;
    assign o_out.entry_length = r_o_len;

    // The count never exceeds the table's capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // A table write never lands beyond the last entry.
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_n < CW'(CAPACITY)))
        else $error("table write beyond capacity");

    // An accepted beat always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != isa_pkg::S_IDLE))
        else $error("accepted beat left the sequencer idle");

    // A fresh result comes only from the result state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == isa_pkg::S_DONE))
        else $error("result raised outside the result state");

endmodule
